FILE: src/fbcs_pkg.sv
`default_nettype none

package fbcs_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int CRC_BYTES   = 62;
   localparam int MAX_BLOCKS  = 1024;

   localparam int BYTE_W       = 8;
   localparam int INDEX_W      = $clog2(BLOCK_BYTES);
   localparam int BLOCK_W      = $clog2(MAX_BLOCKS);
   localparam int ID_W         = 16;
   localparam int CRC_W        = 16;
   localparam int OFFSET_W     = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int RSP_FIELDS_W = BLOCK_W + 3 + OFFSET_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [INDEX_W-1:0] LAST_INDEX    = INDEX_W'(BLOCK_BYTES - 1);
   localparam logic [INDEX_W-1:0] ID_HIGH_INDEX = INDEX_W'(1);
   localparam logic [INDEX_W-1:0] CRC_LO_INDEX  = INDEX_W'(CRC_BYTES);
   localparam logic [INDEX_W-1:0] CRC_HI_INDEX  = INDEX_W'(CRC_BYTES + 1);

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   localparam logic [BLOCK_W-1:0] FIRST_BLOCK_RESET = BLOCK_W'(2);

   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_ID   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_BLOCK = 1'b1;

   typedef struct packed {
      logic                scan_done;
      logic [OFFSET_W-1:0] best_offset;
      logic                found;
      logic                crc_ok;
      logic                id_match;
      logic [BLOCK_W-1:0]  block_number;
   } rsp_type;

   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: src/fbcs_engine.sv
`default_nettype none

module fbcs_engine
   import fbcs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [BYTE_W-1:0]   data_byte,
   input  wire logic                end_of_scan,
   input  wire logic [ID_W-1:0]     target_block_id,
   input  wire logic [BLOCK_W-1:0]  first_block_number,
   output logic                     emit,
   output rsp_type                  result
);

   logic [CRC_W-1:0]    crc_ff, crc_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [BLOCK_W-1:0]  block_ff, block_in;
   logic [BYTE_W-1:0]   id_low_ff, id_low_in;
   logic                id_equal_ff, id_equal_in;
   logic [BYTE_W-1:0]   crc_low_ff, crc_low_in;
   logic                crc_good_ff, crc_good_in;
   logic [OFFSET_W-1:0] best_ff, best_in;
   logic                found_ff, found_in;
   logic                in_scan_ff, in_scan_in;

   logic [BLOCK_W-1:0]  cur_block;
   logic                complete;
   logic                id_equal_now;
   logic                crc_good_now;
   logic                hit;
   logic                found_now;
   logic [OFFSET_W-1:0] best_now;

   always_comb begin
      cur_block    = in_scan_ff ? block_ff : first_block_number;
      complete     = (index_ff == LAST_INDEX);
      id_equal_now = (index_ff == ID_HIGH_INDEX)
                     ? ({data_byte, id_low_ff} == target_block_id) : id_equal_ff;
      crc_good_now = (index_ff == CRC_HI_INDEX)
                     ? ((~crc_ff) == {data_byte, crc_low_ff}) : crc_good_ff;
      hit          = complete && id_equal_now && crc_good_now;
      found_now    = found_ff || hit;
      best_now     = hit ? {cur_block, INDEX_W'(0)} : best_ff;
      emit         = complete || end_of_scan;

      result.block_number = cur_block;
      result.id_match     = complete && id_equal_now;
      result.crc_ok       = complete && crc_good_now;
      result.found        = found_now;
      result.best_offset  = best_now;
      result.scan_done    = end_of_scan;

      crc_in      = crc_ff;
      index_in    = index_ff;
      block_in    = block_ff;
      id_low_in   = id_low_ff;
      id_equal_in = id_equal_ff;
      crc_low_in  = crc_low_ff;
      crc_good_in = crc_good_ff;
      best_in     = best_ff;
      found_in    = found_ff;
      in_scan_in  = in_scan_ff;

      if (step) begin
         if (end_of_scan) begin
            crc_in      = CRC_INIT;
            index_in    = '0;
            id_low_in   = '0;
            id_equal_in = 1'b0;
            crc_low_in  = '0;
            crc_good_in = 1'b0;
            best_in     = '0;
            found_in    = 1'b0;
            in_scan_in  = 1'b0;
         end else if (complete) begin
            crc_in      = CRC_INIT;
            index_in    = '0;
            id_low_in   = '0;
            id_equal_in = 1'b0;
            crc_low_in  = '0;
            crc_good_in = 1'b0;
            best_in     = best_now;
            found_in    = found_now;
            block_in    = cur_block + BLOCK_W'(1);
            in_scan_in  = 1'b1;
         end else begin
            if (index_ff == '0) begin
               id_low_in = data_byte;
            end
            if (index_ff < CRC_LO_INDEX) begin
               crc_in = crc_byte(crc_ff, data_byte);
            end else if (index_ff == CRC_LO_INDEX) begin
               crc_low_in = data_byte;
            end
            id_equal_in = id_equal_now;
            crc_good_in = crc_good_now;
            index_in    = index_ff + INDEX_W'(1);
            block_in    = cur_block;
            in_scan_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= CRC_INIT;
         index_ff    <= '0;
         block_ff    <= '0;
         id_low_ff   <= '0;
         id_equal_ff <= 1'b0;
         crc_low_ff  <= '0;
         crc_good_ff <= 1'b0;
         best_ff     <= '0;
         found_ff    <= 1'b0;
         in_scan_ff  <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         index_ff    <= index_in;
         block_ff    <= block_in;
         id_low_ff   <= id_low_in;
         id_equal_ff <= id_equal_in;
         crc_low_ff  <= crc_low_in;
         crc_good_ff <= crc_good_in;
         best_ff     <= best_in;
         found_ff    <= found_in;
         in_scan_ff  <= in_scan_in;
      end
   end

   a_best_zero_until_found: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> best_ff == '0)
      else $error("best offset set without a hit");

   a_index_clears_after_result: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> index_ff == '0 && crc_ff == CRC_INIT)
      else $error("block state not cleared after result");

   a_scan_end_clears: assert property (@(posedge clock) disable iff (reset)
      step && end_of_scan |=> !in_scan_ff && !found_ff)
      else $error("scan state not cleared at scan end");

endmodule

`default_nettype wire

FILE: src/flash_block_crc_scanner.sv
// Scans the 64-byte blocks of a flash partition, one byte per request in physical
// order, and sends one response per completed block (and one at scan end, with
// rsp_tlast set; a trailing partial block reports id_match and crc_ok as 0). Each
// response carries the block number, whether the little-endian id in bytes 0-1
// equals target_block_id, whether the CRC-16 (0x1021, init 0xFFFF, inverted) over
// bytes 0-61 equals the little-endian CRC in bytes 62-63, and the byte offset of
// the latest block that passed both checks. The block takes one byte every cycle
// while not stalled; a byte goes through an input register and the CRC/compare
// logic into the response register, and input stalls only while that response
// register is full and not taken. first_block_number is sampled on the first byte
// of each scan; write registers only while no scan is in progress.

`default_nettype none

module flash_block_crc_scanner
   import fbcs_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // data_byte
   input  wire logic                   req_tlast,   // end_of_scan

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // block_number[9:0], id_match[10], crc_ok[11], found[12], best_offset[28:13]
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast,   // scan_done

   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [ID_W-1:0]    target_id_ff;
   logic [BLOCK_W-1:0] first_block_ff;

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;

   logic               emit;
   logic               out_free;
   logic               step;
   rsp_type            result;

   fbcs_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .step               (step),
      .data_byte          (in_byte_ff),
      .end_of_scan        (in_last_ff),
      .target_block_id    (target_id_ff),
      .first_block_number (first_block_ff),
      .emit               (emit),
      .result             (result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      step         = in_valid_ff && (!emit || out_free);
      req_tready   = !in_valid_ff || step;
      rsp_valid_in = (step && emit) || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff   <= '0;
         first_block_ff <= FIRST_BLOCK_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_TARGET_ID:   target_id_ff   <= csr_wdata;
               REG_FIRST_BLOCK: first_block_ff <= csr_wdata[BLOCK_W-1:0];
               default: ;
            endcase
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.scan_done;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.best_offset, rsp_ff.found, rsp_ff.crc_ok,
                                    rsp_ff.id_match, rsp_ff.block_number});

   a_hit_sets_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.id_match && rsp_ff.crc_ok |-> rsp_ff.found)
      else $error("matching valid block not reported as found");

   a_hit_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.id_match && rsp_ff.crc_ok |->
         rsp_ff.best_offset == {rsp_ff.block_number, INDEX_W'(0)})
      else $error("best offset does not follow the matching block");

   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled request lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(step && emit))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fbcs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } flash_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   flash_byte_type byte_queue[$];
   rsp_type        block_reports[$];

   logic [ID_W-1:0]    cfg_target = '0;
   logic [BLOCK_W-1:0] cfg_first = FIRST_BLOCK_RESET;

   bit                 scan_open = 1'b0;
   logic [INDEX_W-1:0] byte_pos = '0;
   logic [BLOCK_W-1:0] blk_no = '0;
   logic [BYTE_W-1:0]  id_lo = '0;
   bit                 id_hit = 1'b0;
   logic [BYTE_W-1:0]  crc_lo = '0;
   bit                 crc_pass = 1'b0;
   logic [CRC_W-1:0]   run_crc = CRC_INIT;
   bit                 hit_seen = 1'b0;
   logic [OFFSET_W-1:0] best_off = '0;

   int  errors = 0;
   int  bytes_taken = 0;
   int  reports_due = 0;
   int  reports_seen = 0;
   int  hit_count = 0;
   int  scan_count = 0;
   int  settings_used = 1;
   int  cycles = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  calm = 1'b0;
   bit  long_hold_done = 1'b0;

   flash_block_crc_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb = c[CRC_W-1] ^ b[i];
         c = c << 1;
         if (fb) begin
            c = c ^ 16'h1021;
         end
      end
      return c;
   endfunction

   task automatic clear_block_state();
      run_crc  = CRC_INIT;
      byte_pos = '0;
      id_lo    = '0;
      id_hit   = 1'b0;
      crc_lo   = '0;
      crc_pass = 1'b0;
   endtask

   task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic last);
      bit      done_blk;
      bit      match;
      bit      ok;
      rsp_type rpt;
      match = 1'b0;
      ok = 1'b0;
      if (!scan_open) begin
         scan_open = 1'b1;
         blk_no = cfg_first;
      end
      if (byte_pos == 0) begin
         id_lo = b;
      end else if (byte_pos == 1) begin
         id_hit = ({b, id_lo} == cfg_target);
      end
      if (byte_pos < CRC_BYTES) begin
         run_crc = crc_update(run_crc, b);
      end else if (byte_pos == CRC_BYTES) begin
         crc_lo = b;
      end else if (byte_pos == CRC_BYTES + 1) begin
         crc_pass = (~run_crc == {b, crc_lo});
      end
      done_blk = (byte_pos == BLOCK_BYTES - 1);
      if (done_blk) begin
         match = id_hit;
         ok = crc_pass;
         if (match && ok) begin
            hit_seen = 1'b1;
            best_off = {blk_no, 6'b0};
            hit_count++;
         end
      end
      if (!done_blk && !last) begin
         byte_pos = byte_pos + 1'b1;
      end else begin
         rpt.block_number = blk_no;
         rpt.id_match     = match;
         rpt.crc_ok       = ok;
         rpt.found        = hit_seen;
         rpt.best_offset  = best_off;
         rpt.scan_done    = last;
         block_reports.push_back(rpt);
         reports_due++;
         clear_block_state();
         if (last) begin
            scan_open = 1'b0;
            hit_seen = 1'b0;
            best_off = '0;
            scan_count++;
         end else begin
            blk_no = blk_no + 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic check_report();
      rsp_type want;
      rsp_type got;
      got = rsp_type'({rsp_tlast, rsp_tdata[RSP_FIELDS_W-1:0]});
      if (block_reports.size() == 0) begin
         $error("block report with none pending: tdata %h tlast %b", rsp_tdata, rsp_tlast);
         errors++;
      end else begin
         want = block_reports.pop_front();
         check_field("block_number", want.block_number, got.block_number);
         check_field("id_match", want.id_match, got.id_match);
         check_field("crc_ok", want.crc_ok, got.crc_ok);
         check_field("found", want.found, got.found);
         check_field("best_offset", want.best_offset, got.best_offset);
         check_field("scan_done", want.scan_done, got.scan_done);
      end
      reports_seen++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      flash_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            scan_byte(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 7) - 1;
            req_tvalid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            nxt = byte_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.data;
            req_tlast  <= nxt.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_report();
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && reports_seen >= 8 && byte_queue.size() > 100) begin
            long_hold_done = 1'b1;
            recv_gap = 299;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      flash_byte_type item;
      item.data = b;
      item.last = last;
      byte_queue.push_back(item);
   endtask

   task automatic queue_block(input bit ends_scan);
      logic [BYTE_W-1:0] blk[BLOCK_BYTES];
      logic [ID_W-1:0]   id;
      logic [CRC_W-1:0]  crc;
      int                stop_at;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         blk[i] = BYTE_W'($urandom);
      end
      if ($urandom_range(0, 9) < 8) begin
         case ($urandom_range(0, 3))
            0, 1: id = cfg_target;
            2: id = cfg_target ^ (16'h1 << $urandom_range(0, 15));
            default: id = ID_W'($urandom);
         endcase
         blk[0] = id[7:0];
         blk[1] = id[15:8];
         crc = CRC_INIT;
         for (int i = 0; i < CRC_BYTES; i++) begin
            crc = crc_update(crc, blk[i]);
         end
         crc = ~crc;
         if ($urandom_range(0, 3) == 0) begin
            crc = crc ^ (16'h1 << $urandom_range(0, 15));
         end
         blk[CRC_BYTES]     = crc[7:0];
         blk[CRC_BYTES + 1] = crc[15:8];
      end
      stop_at = BLOCK_BYTES - 1;
      if (ends_scan && $urandom_range(0, 1) == 1) begin
         stop_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2)
                                               : $urandom_range(0, BLOCK_BYTES - 2);
      end
      for (int i = 0; i <= stop_at; i++) begin
         push_byte(blk[i], ends_scan && i == stop_at);
      end
   endtask

   task automatic settle();
      while (byte_queue.size() != 0 || req_tvalid || block_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_TARGET_ID) begin
         cfg_target = value;
      end else begin
         cfg_first = value[BLOCK_W-1:0];
      end
   endtask

   task automatic run_phase(input logic [ID_W-1:0] target, input logic [BLOCK_W-1:0] first);
      int nblk;
      csr_write(REG_TARGET_ID, target);
      csr_write(REG_FIRST_BLOCK, CSR_DATA_W'(first));
      settings_used++;
      repeat ($urandom_range(1, 4)) begin
         nblk = $urandom_range(1, 3);
         for (int b = 0; b < nblk; b++) begin
            queue_block(b == nblk - 1);
         end
      end
      settle();
   endtask

   initial begin
      int phase;
      phase = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      push_byte(8'h00, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hA5, 1'b1);
      settle();

      while (bytes_taken < 1150) begin
         if (bytes_taken >= 850) begin
            calm = 1'b1;
         end
         case (phase)
            0: run_phase(16'hFFFF, 10'd1023);
            1: run_phase(16'h0000, 10'd0);
            2: run_phase(16'h8001, 10'd1022);
            default: run_phase(ID_W'($urandom), BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1)));
         endcase
         phase++;
      end

      repeat (10) @(negedge clock);
      $display("Scanned %0d flash bytes in %0d scans under %0d register settings.",
               bytes_taken, scan_count, settings_used);
      $display("Checked %0d of %0d predicted block reports, %0d matching id with good CRC.",
               reports_seen, reports_due, hit_count);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
